// ===== rtl/core/wsbtd_pkg.sv =====
// Package with constants and coefficient tables for the windowed single-bin tone detector.
`default_nettype none
package wsbtd_pkg;

  localparam int WindowLen = 100;
  localparam int BinPeriod = 10;
  localparam int WarmupEvals = 10;
  localparam int PosW = $clog2(WindowLen);
  localparam int PhW = $clog2(BinPeriod);
  localparam int MagW = 23;
  localparam int DlW = 8;
  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};
  localparam logic [MagW-1:0] ThresholdReset = 23'd500;
  localparam logic [DlW-1:0] DeadlineReset = 8'd30;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_DEADLINE  = 1'b1
  } cfg_index_t;

  // Exact Q1.15 Hann values for the first half of the window.
  function automatic logic signed [16:0] hann_exact(input logic [PosW-1:0] m);
    logic [15:0] v;
    case (m)
      7'd0: v = 16'd0;     7'd1: v = 16'd32;    7'd2: v = 16'd129;   7'd3: v = 16'd290;
      7'd4: v = 16'd515;   7'd5: v = 16'd802;   7'd6: v = 16'd1151;  7'd7: v = 16'd1559;
      7'd8: v = 16'd2027;  7'd9: v = 16'd2551;  7'd10: v = 16'd3129; 7'd11: v = 16'd3760;
      7'd12: v = 16'd4441; 7'd13: v = 16'd5168; 7'd14: v = 16'd5940; 7'd15: v = 16'd6754;
      7'd16: v = 16'd7605; 7'd17: v = 16'd8491; 7'd18: v = 16'd9408; 7'd19: v = 16'd10353;
      7'd20: v = 16'd11321; 7'd21: v = 16'd12309; 7'd22: v = 16'd13314; 7'd23: v = 16'd14331;
      7'd24: v = 16'd15355; 7'd25: v = 16'd16384; 7'd26: v = 16'd17413; 7'd27: v = 16'd18437;
      7'd28: v = 16'd19454; 7'd29: v = 16'd20459; 7'd30: v = 16'd21447; 7'd31: v = 16'd22415;
      7'd32: v = 16'd23360; 7'd33: v = 16'd24277; 7'd34: v = 16'd25163; 7'd35: v = 16'd26014;
      7'd36: v = 16'd26828; 7'd37: v = 16'd27600; 7'd38: v = 16'd28327; 7'd39: v = 16'd29008;
      7'd40: v = 16'd29639; 7'd41: v = 16'd30217; 7'd42: v = 16'd30741; 7'd43: v = 16'd31209;
      7'd44: v = 16'd31617; 7'd45: v = 16'd31966; 7'd46: v = 16'd32253; 7'd47: v = 16'd32478;
      7'd48: v = 16'd32639; 7'd49: v = 16'd32736; 7'd50: v = 16'd32767;
      default: v = 16'd0;
    endcase
    return $signed({1'b0, v});
  endfunction

  function automatic logic signed [16:0] hann_coef(input logic [PosW-1:0] j);
    logic [PosW-1:0] m;
    m = (j > PosW'(WindowLen / 2)) ? PosW'(WindowLen) - j : j;
    return hann_exact(m);
  endfunction

  // Cosine at phase k/BinPeriod in Q1.15.
  function automatic logic signed [16:0] cos_coef(input logic [PhW-1:0] k);
    logic signed [16:0] r;
    case (k)
      4'd0: r = 17'sd32767;  4'd1: r = 17'sd26510;  4'd2: r = 17'sd10126;
      4'd3: r = -17'sd10126; 4'd4: r = -17'sd26510; 4'd5: r = -17'sd32767;
      4'd6: r = -17'sd26510; 4'd7: r = -17'sd10126; 4'd8: r = 17'sd10126;
      4'd9: r = 17'sd26510;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

  // Sine at phase k/BinPeriod in Q1.15.
  function automatic logic signed [16:0] sin_coef(input logic [PhW-1:0] k);
    logic signed [16:0] r;
    case (k)
      4'd0: r = 17'sd0;      4'd1: r = 17'sd19261;  4'd2: r = 17'sd31164;
      4'd3: r = 17'sd31164;  4'd4: r = 17'sd19261;  4'd5: r = 17'sd0;
      4'd6: r = -17'sd19261; 4'd7: r = -17'sd31164; 4'd8: r = -17'sd31164;
      4'd9: r = -17'sd19261;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wsbtd_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module wsbtd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitm;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitm <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("root done while still busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("root done held two cycles");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("root did not start");

endmodule
`default_nettype wire

// ===== rtl/core/windowed_single_bin_tone_detector_core.sv =====
// Top level of the windowed single-bin tone detector.
// A reference load, or any sample once the detector has stopped, goes straight to output;
// a sample that does not finish a block of ten is first written to the difference memory,
// and one that does is then accumulated, drained, rounded, squared, rooted and output.
// One item is in work at a time; the next item can be taken as soon as a result appears.
// Reset is synchronous: control state and flags clear and configuration takes its reset
// values; the difference memory is swept to zero after reset, during which no item is taken.
`default_nettype none
module windowed_single_bin_tone_detector_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample
  input  wire logic        s_axis_tuser,   // load_reference
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // magnitude, then zero fill
  output logic [2:0]       m_axis_tuser,   // evaluated, confirmed, stop
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [22:0] cfg_data
);

  localparam int PosW = wsbtd_pkg::PosW;
  localparam int PhW  = wsbtd_pkg::PhW;
  localparam int MagW = wsbtd_pkg::MagW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_ACC, S_DRAIN, S_ROUND, S_SQUARE, S_ROOT, S_OUT
  } state_t;

  state_t state;
  logic [15:0] ring [wsbtd_pkg::WindowLen];
  logic [PosW-1:0] wr_pos, rd_pos, j_cnt, clr_pos;
  logic [PhW-1:0]  ph, ph_j;
  logic            ring_we;
  logic [PosW-1:0] ring_waddr;
  logic [15:0]     ring_wdata, ring_rdata;
  logic [31:0]     prev;
  logic [7:0]      eval_cnt;
  logic            confirmed, stopped;
  logic [MagW-1:0] last_mag, threshold;
  logic [7:0]      deadline;
  logic [31:0]     sample_r;
  logic            evaluated;
  logic signed [63:0] re_acc, im_acc;
  logic signed [33:0] wd;
  logic [PosW-1:0] j_d;
  logic [PhW-1:0]  ph_d, ph_d2;
  logic            v1, v2;
  logic [63:0]     rad;
  logic            rt_start, rt_done;
  logic [31:0]     rt_root;
  logic [32:0]     mag_full;
  logic [MagW-1:0] mag_new;
  logic [7:0]      cnt_new;
  logic [31:0]     r4, i4;
  logic [63:0]     re_abs, im_abs;
  logic [15:0]     diff;
  logic            out_free;

  assign diff = sample_r[15:0] - prev[15:0];

  always_ff @(posedge clk) begin
    if (ring_we) ring[ring_waddr] <= ring_wdata;
    ring_rdata <= ring[rd_pos];
  end

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = wr_pos;
    ring_wdata = diff;
    if (state == S_CLEAR) begin
      ring_we = 1'b1;
      ring_waddr = clr_pos;
      ring_wdata = '0;
    end else if (state == S_WRITE) begin
      ring_we = 1'b1;
    end
  end

  wsbtd_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(rt_start), .radicand(rad), .done(rt_done), .root(rt_root)
  );

  assign re_abs = re_acc[63] ? 64'(-re_acc) : 64'(re_acc);
  assign im_abs = im_acc[63] ? 64'(-im_acc) : 64'(im_acc);
  assign mag_full = ({1'b0, rt_root} + 33'd8) >> 4;
  assign mag_new = (mag_full > {10'd0, wsbtd_pkg::MagMax}) ? wsbtd_pkg::MagMax
                                                           : mag_full[MagW-1:0];
  assign cnt_new = (eval_cnt == 8'hff) ? eval_cnt : eval_cnt + 8'd1;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_pos <= '0;
      wr_pos <= '0;
      ph <= '0;
      prev <= '0;
      eval_cnt <= '0;
      confirmed <= 1'b0;
      stopped <= 1'b0;
      last_mag <= '0;
      threshold <= wsbtd_pkg::ThresholdReset;
      deadline <= wsbtd_pkg::DeadlineReset;
      m_axis_tvalid <= 1'b0;
      rt_start <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      rt_start <= (state == S_SQUARE);
      if (cfg_we) begin
        case (cfg_index)
          wsbtd_pkg::CFG_THRESHOLD: threshold <= cfg_data;
          wsbtd_pkg::CFG_DEADLINE:  deadline <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == S_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_pos <= clr_pos + PosW'(1);
          if (clr_pos == PosW'(wsbtd_pkg::WindowLen - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            evaluated <= 1'b0;
            sample_r <= s_axis_tdata;
            if (stopped) begin
              state <= S_OUT;
            end else if (s_axis_tuser) begin
              prev <= s_axis_tdata;
              state <= S_OUT;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          prev <= sample_r;
          if (wr_pos == PosW'(wsbtd_pkg::WindowLen - 1)) begin
            wr_pos <= '0;
            rd_pos <= '0;
          end else begin
            wr_pos <= wr_pos + PosW'(1);
            rd_pos <= wr_pos + PosW'(1);
          end
          if (ph == PhW'(wsbtd_pkg::BinPeriod - 1)) begin
            ph <= '0;
            state <= S_ACC;
            j_cnt <= '0;
            ph_j <= '0;
            re_acc <= '0;
            im_acc <= '0;
          end else begin
            ph <= ph + PhW'(1);
            state <= S_OUT;
          end
        end
        S_ACC: begin
          // Memory read issued this cycle; data and coefficients line up in the next cycle.
          v1 <= 1'b1;
          j_d <= j_cnt;
          ph_d <= ph_j;
          ph_j <= (ph_j == PhW'(wsbtd_pkg::BinPeriod - 1)) ? '0 : ph_j + PhW'(1);
          rd_pos <= (rd_pos == PosW'(wsbtd_pkg::WindowLen - 1)) ? '0 : rd_pos + PosW'(1);
          j_cnt <= j_cnt + PosW'(1);
          if (j_cnt == PosW'(wsbtd_pkg::WindowLen - 1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          v1 <= 1'b0;
          if (!v1 && !v2) state <= S_ROUND;
        end
        S_ROUND: begin
          r4 <= 32'((re_abs + 64'd33554432) >> 26);
          i4 <= 32'((im_abs + 64'd33554432) >> 26);
          state <= S_SQUARE;
        end
        S_SQUARE: begin
          rad <= 64'(r4) * 64'(r4) + 64'(i4) * 64'(i4);
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (rt_done) begin
            evaluated <= 1'b1;
            last_mag <= mag_new;
            eval_cnt <= cnt_new;
            if (cnt_new >= 8'(wsbtd_pkg::WarmupEvals)) begin
              if (mag_new > threshold) begin
                if (cnt_new < deadline) confirmed <= 1'b1;
                else if (confirmed) stopped <= 1'b1;
              end else if (cnt_new > deadline && !confirmed) begin
                stopped <= 1'b1;
              end
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_ACC && state != S_DRAIN) v1 <= 1'b0;
      // Stage one: window times difference; stage two: times cosine and sine.
      v2 <= v1;
      if (v1) begin
        wd <= 34'(wsbtd_pkg::hann_coef(j_d)) * 34'($signed(ring_rdata));
        ph_d2 <= ph_d;
      end
      if (v2) begin
        re_acc <= re_acc + 64'(wd * 51'(wsbtd_pkg::cos_coef(ph_d2)));
        im_acc <= im_acc - 64'(wd * 51'(wsbtd_pkg::sin_coef(ph_d2)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= {1'b0, last_mag};
      m_axis_tuser <= {stopped, confirmed, evaluated};
    end
  end

  assert property (@(posedge clk) disable iff (rst) stopped |=> stopped)
    else $error("stop flag cleared");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("waiting result changed");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && stopped) |=> $stable(last_mag))
    else $error("magnitude changed after stop");

endmodule
`default_nettype wire
